// ===== src/rbst_pkg.sv =====
package rbst_pkg;

  // Coordinate format: signed Q16.16
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_BITS  = 2 * COORD_BITS;

  localparam int NUM_AXES    = 3;
  localparam int NUM_IN      = 8;
  localparam int PIPE_STAGES = 5;

  // Packed stream widths (rounded up to whole bytes)
  localparam int IN_BITS  = NUM_IN * COORD_BITS;
  localparam int OUT_RAW  = 1 + 2 * COORD_BITS;
  localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

  // Configuration register indexes
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Pipeline control shared by lanes and merge stage
  typedef struct packed {
    logic                   en;
    logic [PIPE_STAGES-1:0] vld;
  } pipe_ctl_t;

  typedef struct packed {
    coord_t range_end;
    coord_t range_start;
  } range_t;

  // a - b, clamped to the coordinate range
  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS] != d[COORD_BITS-1]) begin
      return d[COORD_BITS] ? COORD_MIN : COORD_MAX;
    end
    return d[COORD_BITS-1:0];
  endfunction

  // Floor shift of a full product, then clamp to the coordinate range
  function automatic coord_t scale_sat(input prod_t p);
    prod_t q;
    q = p >>> FRAC_BITS;
    if (q > prod_t'(COORD_MAX)) begin
      return COORD_MAX;
    end
    if (q < prod_t'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return q[COORD_BITS-1:0];
  endfunction

endpackage

// ===== src/ray_box_slab_test_top.sv =====
// Ray versus axis-aligned box slab test, signed Q16.16.
// Pipeline stages from input transaction to m_tvalid: sub, multiply,
// rescale/order, merge, range check. Throughput: one ray per cycle while not halted.
// The five-stage pipeline halts as a whole only while m_tvalid is high and m_tready low.
// Reset (rst, synchronous) empties the pipeline and clears the box registers to 0.
module ray_box_slab_test_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
  // range_start, range_end (32 bits each, from bit 0 up)
  input  logic [rbst_pkg::IN_BITS-1:0]          s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // hit[0], t_enter[32:1], t_exit[64:33], zero pad above
  output logic [rbst_pkg::OUT_BITS-1:0]         m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_we,
  input  logic [rbst_pkg::REG_IDX_BITS-1:0]     cfg_addr,
  input  logic [rbst_pkg::COORD_BITS-1:0]       cfg_data
);

  localparam int CB = rbst_pkg::COORD_BITS;
  localparam int NA = rbst_pkg::NUM_AXES;

  rbst_pkg::coord_t    box_min [NA];
  rbst_pkg::coord_t    box_max [NA];
  rbst_pkg::coord_t    near    [NA];
  rbst_pkg::coord_t    far     [NA];
  rbst_pkg::range_t    range_d [3];
  rbst_pkg::range_t    range_in;
  rbst_pkg::pipe_ctl_t ctl;
  logic [rbst_pkg::PIPE_STAGES-1:0] vld;
  logic                en;
  logic                hit;
  rbst_pkg::coord_t    t_enter;
  rbst_pkg::coord_t    t_exit;

  // box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        rbst_pkg::REG_BOX_MIN_X: box_min[0] <= cfg_data;
        rbst_pkg::REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        rbst_pkg::REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        rbst_pkg::REG_BOX_MAX_X: box_max[0] <= cfg_data;
        rbst_pkg::REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        rbst_pkg::REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and stage valids
  assign en       = !vld[rbst_pkg::PIPE_STAGES-1] || m_tready;
  assign s_tready = en;
  assign ctl.en   = en;
  assign ctl.vld  = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[rbst_pkg::PIPE_STAGES-2:0], s_tvalid};
    end
  end

  // range fields ride alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      range_d[0] <= {s_tdata[7*CB +: CB], s_tdata[6*CB +: CB]};
      range_d[1] <= range_d[0];
      range_d[2] <= range_d[1];
    end
  end
  assign range_in = range_d[2];

  // one lane per axis
  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbst_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .box_min (box_min[a]),
      .box_max (box_max[a]),
      .origin  (s_tdata[a*CB +: CB]),
      .inv_dir (s_tdata[(NA+a)*CB +: CB]),
      .near    (near[a]),
      .far     (far[a])
    );
  end

  rbst_merge u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .near     (near),
    .far      (far),
    .range_in (range_in),
    .hit      (hit),
    .t_enter  (t_enter),
    .t_exit   (t_exit)
  );

  assign m_tvalid = vld[rbst_pkg::PIPE_STAGES-1];
  assign m_tdata  = {{(rbst_pkg::OUT_BITS-rbst_pkg::OUT_RAW){1'b0}}, t_exit, t_enter, hit};

  a_reset_empty: assert property (@(posedge clk)
    rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valids moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted transaction lost at first stage");

endmodule

// ===== src/rbst_lane.sv =====
// One axis: slab distances to both box planes, sorted into near and far.
module rbst_lane (
  input  logic              clk,
  input  rbst_pkg::pipe_ctl_t ctl,
  input  rbst_pkg::coord_t  box_min,
  input  rbst_pkg::coord_t  box_max,
  input  rbst_pkg::coord_t  origin,
  input  rbst_pkg::coord_t  inv_dir,
  output rbst_pkg::coord_t  near,
  output rbst_pkg::coord_t  far
);

  rbst_pkg::coord_t d_min;
  rbst_pkg::coord_t d_max;
  rbst_pkg::coord_t inv_d;
  rbst_pkg::prod_t  p_min;
  rbst_pkg::prod_t  p_max;
  rbst_pkg::coord_t t_min;
  rbst_pkg::coord_t t_max;

  // stage 1: plane minus origin
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      d_min <= rbst_pkg::sat_sub(box_min, origin);
      d_max <= rbst_pkg::sat_sub(box_max, origin);
      inv_d <= inv_dir;
    end
  end

  // stage 2: full-width products
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_min <= d_min * inv_d;
      p_max <= d_max * inv_d;
    end
  end

  // stage 3: rescale, clamp and order
  always_comb begin
    t_min = rbst_pkg::scale_sat(p_min);
    t_max = rbst_pkg::scale_sat(p_max);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      near <= (t_max < t_min) ? t_max : t_min;
      far  <= (t_max < t_min) ? t_min : t_max;
    end
  end

  a_near_le_far: assert property (@(posedge clk) disable iff (ctl.en === 1'bx)
    ctl.vld[2] |-> near <= far)
    else $error("lane near exceeds far");

endmodule

// ===== src/rbst_merge.sv =====
// Combines per-axis intervals into entry/exit and decides the hit.
module rbst_merge (
  input  logic                 clk,
  input  rbst_pkg::pipe_ctl_t  ctl,
  input  rbst_pkg::coord_t     near [rbst_pkg::NUM_AXES],
  input  rbst_pkg::coord_t     far  [rbst_pkg::NUM_AXES],
  input  rbst_pkg::range_t     range_in,
  output logic                 hit,
  output rbst_pkg::coord_t     t_enter,
  output rbst_pkg::coord_t     t_exit
);

  rbst_pkg::coord_t enter_c;
  rbst_pkg::coord_t exit_c;
  rbst_pkg::coord_t enter_r;
  rbst_pkg::coord_t exit_r;
  rbst_pkg::range_t range_r;

  // largest near, smallest far over the axes
  always_comb begin
    enter_c = near[0];
    exit_c  = far[0];
    for (int a = 1; a < rbst_pkg::NUM_AXES; a++) begin
      if (near[a] > enter_c) begin
        enter_c = near[a];
      end
      if (far[a] < exit_c) begin
        exit_c = far[a];
      end
    end
  end

  // stage 4: interval registers
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      enter_r <= enter_c;
      exit_r  <= exit_c;
      range_r <= range_in;
    end
  end

  // stage 5: range check and hit, output register
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      hit     <= !(range_r.range_end < enter_r) && !(exit_r < range_r.range_start)
                 && !exit_r[rbst_pkg::COORD_BITS-1] && !(exit_r < enter_r);
      t_enter <= enter_r;
      t_exit  <= exit_r;
    end
  end

  a_hit_exit_pos: assert property (@(posedge clk) disable iff (ctl.en === 1'bx)
    ctl.vld[4] && hit |-> !t_exit[rbst_pkg::COORD_BITS-1])
    else $error("hit with negative exit");

  a_hit_ordered: assert property (@(posedge clk) disable iff (ctl.en === 1'bx)
    ctl.vld[4] && hit |-> t_exit >= t_enter)
    else $error("hit with exit before entry");

endmodule

// ===== tb/ray_box_checker.sv =====
// Scoreboard for the ray/box slab test: mirrors the box registers, predicts
// one result per accepted ray and compares it with the output stream.
module ray_box_checker
  import rbst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
  // range_start, range_end (from bit 0 up)
  input  logic [IN_BITS-1:0]      s_tdata,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  // hit, t_enter, t_exit, zero pad (from bit 0 up)
  input  logic [OUT_BITS-1:0]     m_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending_count,
  output int                      ray_count,
  output int                      hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Ray as carried on s_tdata (last member sits in the lowest bits)
  typedef struct packed {
    coord_t range_end;
    coord_t range_start;
    coord_t inv_z, inv_y, inv_x;
    coord_t org_z, org_y, org_x;
  } ray_t;

  // Result as carried on m_tdata
  typedef struct packed {
    coord_t t_exit;
    coord_t t_enter;
    logic   hit;
  } slab_result_t;

  coord_t       box_bound [6];
  slab_result_t slab_expect_q [$];

  // bound - origin, clamped to the coordinate range
  function automatic coord_t diff_clamped(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] wide;
    wide = a;
    wide = wide - b;
    if (wide > COORD_MAX) return COORD_MAX;
    if (wide < COORD_MIN) return COORD_MIN;
    return wide[COORD_BITS-1:0];
  endfunction

  // Exact product, floor shift out of the fraction, clamp
  function automatic coord_t slab_dist(coord_t d, coord_t inv);
    longint prod;
    longint scaled;
    prod   = longint'(d) * longint'(inv);
    scaled = prod >>> FRAC_BITS;
    if (scaled > longint'(COORD_MAX)) return COORD_MAX;
    if (scaled < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(scaled);
  endfunction

  function automatic slab_result_t predict_slab(ray_t r);
    coord_t       org [3];
    coord_t       inv [3];
    coord_t       t_a, t_b, near_t, far_t;
    slab_result_t res;
    org = '{r.org_x, r.org_y, r.org_z};
    inv = '{r.inv_x, r.inv_y, r.inv_z};
    res = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      t_a    = slab_dist(diff_clamped(box_bound[REG_BOX_MIN_X + ax], org[ax]), inv[ax]);
      t_b    = slab_dist(diff_clamped(box_bound[REG_BOX_MAX_X + ax], org[ax]), inv[ax]);
      near_t = (t_b < t_a) ? t_b : t_a;
      far_t  = (t_a < t_b) ? t_b : t_a;
      if (ax == 0) begin
        res.t_enter = near_t;
        res.t_exit  = far_t;
      end else begin
        if (near_t > res.t_enter) res.t_enter = near_t;
        if (far_t < res.t_exit)   res.t_exit  = far_t;
      end
    end
    // slab interval outside the accepted range is a miss regardless
    if (r.range_end < res.t_enter || res.t_exit < r.range_start) begin
      res.hit = 1'b0;
    end else begin
      res.hit = (res.t_exit >= 0) && (res.t_exit >= res.t_enter);
    end
    return res;
  endfunction

  // Register mirror, prediction on input transactions, compare on output ones
  always @(posedge clk) begin : score
    slab_result_t got;
    slab_result_t want;
    if (rst) begin
      foreach (box_bound[i]) box_bound[i] = '0;
      slab_expect_q.delete();
    end else begin
      if (cfg_we && cfg_addr <= REG_BOX_MAX_Z) begin
        box_bound[cfg_addr] = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got = slab_result_t'(m_tdata[$bits(slab_result_t)-1:0]);
        if (slab_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] unexpected result transaction: hit=%0b enter=%h exit=%h",
                     $realtime, got.hit, got.t_enter, got.t_exit);
          end
        end else begin
          want = slab_expect_q.pop_front();
          if (got.hit !== want.hit || got.t_enter !== want.t_enter ||
              got.t_exit !== want.t_exit) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch: expected hit=%0b enter=%h exit=%h, got hit=%0b enter=%h exit=%h",
                       $realtime, want.hit, want.t_enter, want.t_exit,
                       got.hit, got.t_enter, got.t_exit);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_slab(ray_t'(s_tdata));
        slab_expect_q.push_back(want);
        ray_count++;
        hit_count += want.hit;
      end
    end
    pending_count = slab_expect_q.size();
  end

endmodule

// ===== tb/tb_ray_box_slab_test_top.sv =====
// Stimulus and verdict for the ray/box slab test block.
module tb_ray_box_slab_test_top import rbst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_RAYS   = 900;
  localparam int RANDOM_PHASES = 6;
  localparam int IDLE_PCT      = 6;
  localparam int SETTLE_CYCLES = PIPE_STAGES + 3;

  localparam coord_t ONE    = 32'sh0001_0000;
  localparam coord_t NEG_EPS = 32'shFFFF_FFFF;

  // indexes with no register behind them
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    coord_t range_end;
    coord_t range_start;
    coord_t inv_z, inv_y, inv_x;
    coord_t org_z, org_y, org_x;
  } ray_t;

  logic                    clk;
  logic                    rst;
  logic [IN_BITS-1:0]      s_tdata;   // origin xyz, inv_dir xyz, range_start, range_end
  logic                    s_tvalid;
  logic                    s_tready;
  logic [OUT_BITS-1:0]     m_tdata;   // hit, t_enter, t_exit, pad
  logic                    m_tvalid;
  logic                    m_tready;
  logic                    cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_addr;
  logic [COORD_BITS-1:0]   cfg_data;

  int fail_count;
  int pending_count;
  int ray_count;
  int hit_count;

  int     idle_pct = IDLE_PCT;
  bit     hold_req = 1'b0;
  int     box_settings = 0;
  coord_t cur_lo [3] = '{default: '0};
  coord_t cur_hi [3] = '{default: '0};

  ray_box_slab_test_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  ray_box_checker slab_chk (
    .clk           (clk),
    .rst           (rst),
    .s_tdata       (s_tdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .m_tdata       (m_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .ray_count     (ray_count),
    .hit_count     (hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Signed random value in [-units, units) whole units, random fraction
  function automatic coord_t rand_span(int units);
    int unsigned w;
    w = $urandom_range(2 * units * 65536 - 1);
    return coord_t'(int'(w) - units * 65536);
  endfunction

  function automatic ray_t mk_ray(coord_t ox, coord_t oy, coord_t oz,
                                  coord_t ix, coord_t iy, coord_t iz,
                                  coord_t rs, coord_t re);
    ray_t r;
    r.org_x = ox; r.org_y = oy; r.org_z = oz;
    r.inv_x = ix; r.inv_y = iy; r.inv_z = iz;
    r.range_start = rs;
    r.range_end   = re;
    return r;
  endfunction

  // Mostly rays near the box, many aimed at it; some with a zero-direction
  // axis; the rest raw noise across all bits
  function automatic ray_t rand_ray();
    int     kind;
    coord_t org [3];
    coord_t inv [3];
    coord_t mag;
    coord_t rs, re;
    bit     toward;
    kind = $urandom_range(99);
    if (kind < 15) begin
      return ray_t'({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      org[ax] = rand_span(8);
      if (kind < 60) begin
        mag     = coord_t'($urandom_range(16 * 65536, 4096));
        toward  = (2 * longint'(org[ax]) < longint'(cur_lo[ax]) + longint'(cur_hi[ax]));
        inv[ax] = toward ? mag : -mag;
      end else begin
        inv[ax] = rand_span(16);
      end
    end
    if ($urandom_range(4) == 0) begin
      inv[$urandom_range(2)] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
    end
    case ($urandom_range(3))
      0: begin rs = '0;           re = COORD_MAX;      end
      1: begin rs = rand_span(8); re = rand_span(32);  end
      2: begin rs = COORD_MIN;    re = rand_span(16);  end
      default: begin rs = '0;     re = rand_span(16);  end
    endcase
    return mk_ray(org[0], org[1], org[2], inv[0], inv[1], inv[2], rs, re);
  endfunction

  // Offer one ray, with random idle cycles first, until accepted
  task automatic send_ray(input ray_t r);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding result plus the latency
  task automatic flush_pipe();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input coord_t val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // New box while idle; a stray write to an unused index rides along
  task automatic program_box(input coord_t lo_x, input coord_t lo_y, input coord_t lo_z,
                             input coord_t hi_x, input coord_t hi_y, input coord_t hi_z);
    flush_pipe();
    write_reg(REG_BOX_MIN_X, lo_x);
    write_reg(REG_BOX_MIN_Y, lo_y);
    write_reg(REG_BOX_MIN_Z, lo_z);
    write_reg(REG_BOX_MAX_X, hi_x);
    write_reg(REG_BOX_MAX_Y, hi_y);
    write_reg(REG_BOX_MAX_Z, hi_z);
    write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, coord_t'($urandom));
    cfg_we <= 1'b0;
    cur_lo = '{lo_x, lo_y, lo_z};
    cur_hi = '{hi_x, hi_y, hi_z};
    box_settings++;
  endtask

  // mode 0: ordered bounds, 1: swapped bounds, 2: raw register values
  task automatic random_box(input int mode);
    coord_t a [3];
    coord_t b [3];
    coord_t t;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      if (mode == 2) begin
        a[ax] = coord_t'($urandom);
        b[ax] = coord_t'($urandom);
      end else begin
        a[ax] = rand_span(4);
        b[ax] = rand_span(4);
        if ((mode == 0) == (b[ax] < a[ax])) begin
          t = a[ax]; a[ax] = b[ax]; b[ax] = t;
        end
      end
    end
    program_box(a[0], a[1], a[2], b[0], b[1], b[2]);
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transaction
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    cfg_we   <= 1'b0;
    cfg_addr <= REG_BOX_MIN_X;
    cfg_data <= '0;
    rst      <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // box registers straight out of reset (all zero)
    repeat (4) send_ray(rand_ray());

    // unit box around the origin
    program_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, 0, COORD_MAX));
    // range ends before entry / starts after exit
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, 0, 2 * ONE));
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, 7 * ONE, COORD_MAX));
    // range touching entry and exit exactly
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, 0, 4 * ONE));
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, 6 * ONE, 6 * ONE));
    // box behind the ray
    send_ray(mk_ray(5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
    // zero direction on y with origin outside that slab
    send_ray(mk_ray(0, 5 * ONE, 0, ONE, COORD_MAX, COORD_MAX, 0, COORD_MAX));
    // negative direction, negative saturated inverses
    send_ray(mk_ray(5 * ONE, 0, 0, -ONE, COORD_MIN, COORD_MIN, 0, COORD_MAX));
    // origin inside the box
    send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, 0, COORD_MAX));
    // extreme origins and inverses: clamped differences and products
    send_ray(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MIN, COORD_MAX));
    send_ray(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MAX));
    // all zero inverse: every distance is zero
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0));
    // tiny negative inverse: floor rounding of small products
    send_ray(mk_ray(-3 * ONE + 1, 2 * ONE - 7, 5, NEG_EPS, NEG_EPS, NEG_EPS,
                    COORD_MIN, COORD_MAX));
    // empty range (start above end)
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN));

    // swapped bounds on every axis
    program_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_ray(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX, 0, COORD_MAX));
    send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, 0, COORD_MAX));

    // box spanning the whole coordinate range
    program_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, 0, COORD_MAX));
    send_ray(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MIN, COORD_MAX));
    send_ray(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MAX));

    // random phases over several boxes; phase 1 starts with the output
    // hold-off, phase 2 runs with no idling on either side
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       random_box(1);
        2:       program_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        4:       random_box(2);
        default: random_box(0);
      endcase
      idle_pct = (ph == 2) ? 0 : IDLE_PCT;
      if (ph == 1) hold_req = 1'b1;
      repeat (RANDOM_RAYS / RANDOM_PHASES) send_ray(rand_ray());
    end

    flush_pipe();
    $display("Covered %0d rays (%0d hits) over %0d box settings, with swapped and full-range",
             ray_count, hit_count, box_settings);
    $display("boxes, saturated inverses, range edges and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
